### src/hkx_pkg.sv
// Shared constants, types and command format of the header keyed XOR skip decoder.
package hkx_pkg;

    // File layout
    localparam int HEADER_BYTES = 28;
    localparam int MAGIC_LEN    = 8;
    localparam int MAGIC_IDX_W  = $clog2(MAGIC_LEN);
    localparam int KEY_OFFSET   = 16;
    localparam int WORD_BYTES   = 4;

    localparam logic [31:0] HDR_LEN      = 32'(HEADER_BYTES);
    localparam logic [31:0] HDR_LAST_POS = 32'(HEADER_BYTES - 1);
    localparam logic [31:0] KEY_LAST_POS = 32'(KEY_OFFSET + WORD_BYTES - 1);
    localparam logic [31:0] MAGIC_LEN32  = 32'(MAGIC_LEN);
    localparam logic [31:0] WORD_LEN32   = 32'(WORD_BYTES);

    // Expected leading bytes of every file
    localparam logic [7:0] MAGIC_BYTES [MAGIC_LEN] = '{
        8'h67, 8'h65, 8'h6d, 8'h74, 8'h72, 8'h61, 8'h64, 8'h65
    };

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Remainder unit
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_SHORT = 2'd1;
    localparam logic [1:0] STS_MAGIC = 2'd2;
    localparam logic [1:0] STS_ZSKIP = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        BK_RUN = 2'b01,
        BK_DIV = 2'b10
    } t_back_st;

    typedef enum logic [1:0] {
        CMD_SETUP = 2'd0,
        CMD_NOTE  = 2'd1,
        CMD_DATA  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [1:0]  status;
        logic [31:0] plen;
        logic [31:0] key;
        logic [31:0] half;
        logic [31:0] skip;
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

### src/hkx_if.sv
// Valid/ready channel interfaces for input bytes, queue commands and results.
interface hkx_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_byte;
    logic        start_flag;
    logic [31:0] file_len;

    modport source (output valid, output in_byte, output start_flag, output file_len,
                    input ready);
    modport sink   (input valid, input in_byte, input start_flag, input file_len,
                    output ready);
endinterface

interface hkx_cmd_if;
    logic          valid;
    logic          ready;
    hkx_pkg::t_cmd cmd;

    modport source (output valid, output cmd, input ready);
    modport sink   (input valid, input cmd, output ready);
endinterface

interface hkx_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic [1:0]  status;
    logic [31:0] end_pos;
    logic [31:0] payload_len;
    logic        last;

    modport source (output valid, output out_byte, output has_byte, output status,
                    output end_pos, output payload_len, output last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input status,
                    input end_pos, input payload_len, input last, output ready);
endinterface

### src/hkx_front.sv
// Front end: tracks file position, parses the header and issues queue commands.
module hkx_front (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hkx_in_if.sink    i_in,
    hkx_cmd_if.source o_cmd
);
    import hkx_pkg::*;

    t_phase      r_phase, n_phase, e_phase;
    logic [31:0] r_byte_pos, n_byte_pos, e_pos;
    logic [31:0] r_total_len, n_total_len, e_len;
    logic [1:0]  r_err, n_err, e_err;
    logic [63:0] r_hs, n_hs, e_hs, hs_new;
    logic [31:0] r_key, n_key, e_key;
    logic [31:0] wa, wb, sum_ab, dif_ab, plen;
    logic        in_file, is_last, has_cmd, accept;
    t_cmd        cmd;

    assign i_in.ready  = o_cmd.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_cmd.valid = i_in.valid && has_cmd;
    assign o_cmd.cmd   = cmd;

    // Restart state when a file begins
    always_comb begin
        if (i_in.start_flag) begin
            e_phase = PH_HEADER;
            e_pos   = '0;
            e_len   = i_in.file_len;
            e_err   = (i_in.file_len < HDR_LEN) ? STS_SHORT : STS_OK;
            e_hs    = '0;
            e_key   = '0;
        end else begin
            e_phase = r_phase;
            e_pos   = r_byte_pos;
            e_len   = r_total_len;
            e_err   = r_err;
            e_hs    = r_hs;
            e_key   = r_key;
        end
    end

    // Header words and position tests
    always_comb begin
        hs_new  = {i_in.in_byte, e_hs[63:8]};
        wa      = hs_new[31:0];
        wb      = hs_new[63:32];
        sum_ab  = wa + wb;
        dif_ab  = wa - wb;
        plen    = e_len - HDR_LEN;
        in_file = e_pos < e_len;
        is_last = e_pos == (e_len - 32'd1);
    end

    // Classify the byte and build its command
    always_comb begin
        n_phase     = e_phase;
        n_byte_pos  = e_pos;
        n_total_len = e_len;
        n_err       = e_err;
        n_hs        = e_hs;
        n_key       = e_key;
        has_cmd     = 1'b0;
        cmd         = '{kind: CMD_NOTE, data_byte: i_in.in_byte, last: is_last,
                        status: STS_OK, plen: plen, key: e_key,
                        half: {1'b0, sum_ab[31:1]}, skip: {1'b0, dif_ab[31:1]}};
        if (e_phase != PH_IDLE) begin
            if (!in_file) begin
                n_phase = PH_IDLE;
            end else begin
                n_byte_pos = e_pos + 32'd1;
                case (e_phase)
                    PH_HEADER: begin
                        if (e_err == STS_OK) begin
                            if (e_pos < MAGIC_LEN32 &&
                                i_in.in_byte != MAGIC_BYTES[e_pos[MAGIC_IDX_W-1:0]]) begin
                                n_err = STS_MAGIC;
                            end
                            n_hs = hs_new;
                            if (e_pos == KEY_LAST_POS) begin
                                n_key = hs_new[63:32];
                            end
                            if (e_pos == HDR_LAST_POS && n_err == STS_OK) begin
                                if (dif_ab[31:1] == '0) begin
                                    n_err = STS_ZSKIP;
                                end else begin
                                    n_phase  = PH_PAYLOAD;
                                    has_cmd  = 1'b1;
                                    cmd.kind = CMD_SETUP;
                                end
                            end
                        end
                        if (is_last) begin
                            has_cmd    = 1'b1;
                            cmd.status = n_err;
                            cmd.plen   = (n_err == STS_OK) ? plen : '0;
                        end
                    end
                    PH_PAYLOAD: begin
                        has_cmd  = 1'b1;
                        cmd.kind = CMD_DATA;
                    end
                    default: begin
                        has_cmd = 1'b0;
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_byte_pos  <= '0;
            r_total_len <= '0;
            r_err       <= STS_OK;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_total_len <= n_total_len;
            r_err       <= n_err;
        end
    end

    // Header data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs  <= '0;
            r_key <= '0;
        end else if (accept) begin
            r_hs  <= n_hs;
            r_key <= n_key;
        end
    end

endmodule

### src/hkx_queue.sv
// Short command queue that decouples the front end from the back end.
module hkx_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hkx_cmd_if.sink   i_push,
    hkx_cmd_if.source o_pop
);
    import hkx_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push, pop;

    assign i_push.ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_pop.valid  = r_cnt != '0;
    assign o_pop.cmd    = r_mem[r_rp];
    assign push         = i_push.valid && i_push.ready;
    assign pop          = o_pop.valid && o_pop.ready;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");

    a_cnt_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count missed a pop");
`endif

endmodule

### src/hkx_div.sv
// Restoring radix-2 remainder unit, one quotient bit per cycle.
module hkx_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hkx_pkg::t_div_req i_req,
    output hkx_pkg::t_div_rsp o_rsp
);
    import hkx_pkg::*;

    logic [31:0]          r_rem, r_dvd, r_dvs, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;
    logic [32:0]          trial, diff;

    // Shift in one dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_dvd[31]};
        diff  = trial - {1'b0, r_dvs};
        n_rem = diff[32] ? trial[31:0] : diff[31:0];
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[30:0], 1'b0};
        end
    end

endmodule

### src/hkx_back.sv
// Back end: key setup, word cursor, payload XOR and result register.
module hkx_back (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hkx_cmd_if.sink   i_cmd,
    hkx_out_if.source o_out
);
    import hkx_pkg::*;

    t_back_st    r_st;
    logic [31:0] r_key, r_half, r_skip, r_plen, r_nmh, r_ws, r_q;
    logic        r_done;
    // cursor look-ahead pipeline
    logic [32:0] r_v8, r_v8_2;
    logic [33:0] r_nx;
    logic        r_cdone, r_cjump;
    logic [31:0] r_s3_ws;
    logic        r_s3_done;
    logic        s3_over;
    // result register
    logic        r_out_valid, r_has, r_last;
    logic [7:0]  r_ob;
    logic [1:0]  r_sts;
    logic [31:0] r_endp, r_plen_o;

    t_cmd        c;
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic        out_free, take, pop, emit, adv, hit, done_a;
    logic [32:0] dq;
    logic [1:0]  k;
    logic [7:0]  ob;
    logic [31:0] ws_a, endp;

    hkx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign c           = i_cmd.cmd;
    assign out_free    = !r_out_valid || o_out.ready;
    assign take        = out_free && (r_st == BK_RUN);
    assign i_cmd.ready = take;
    assign pop         = i_cmd.valid && take;

    // Decode position within the current word
    always_comb begin
        dq     = {1'b0, r_q} - {1'b0, r_ws};
        hit    = !r_done && (dq[32:2] == '0);
        k      = dq[1:0];
        ob     = c.data_byte ^ 8'(r_key >> {k, 3'b000});
        adv    = pop && (c.kind == CMD_DATA) && hit && (k == 2'd3);
        ws_a   = adv ? r_s3_ws : r_ws;
        done_a = adv ? r_s3_done : r_done;
        endp   = done_a ? ws_a : ws_a + WORD_LEN32;
    end

    // Select result fields
    always_comb begin
        div_req.start    = pop && (c.kind == CMD_SETUP);
        div_req.dividend = c.half;
        div_req.divisor  = c.skip;
        case (c.kind)
            CMD_SETUP: emit = c.last;
            CMD_NOTE:  emit = 1'b1;
            CMD_DATA:  emit = 1'b1;
            default:   emit = 1'b0;
        endcase
    end

    // Look ahead to the next word start from the current one
    always_comb begin
        s3_over = ({1'b0, r_nx} + {3'b0, r_half}) > {3'b0, r_plen};
    end

    always_ff @(posedge i_clk) begin
        r_v8      <= {1'b0, r_ws} + 33'd4;
        r_v8_2    <= r_v8;
        r_nx      <= {1'b0, r_v8} + {2'b0, r_skip};
        r_cdone   <= {2'b0, r_plen} <= ({1'b0, r_v8} + 34'd3);
        r_cjump   <= ({1'b0, r_half} <= r_v8) &&
                     (({2'b0, r_half} + {1'b0, r_v8}) < {2'b0, r_plen});
        r_s3_done <= r_cdone;
        if (r_cdone || !r_cjump) begin
            r_s3_ws <= r_v8_2[31:0];
        end else begin
            r_s3_ws <= s3_over ? r_nmh : r_nx[31:0];
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_RUN;
        end else begin
            case (r_st)
                BK_RUN: begin
                    if (div_req.start) begin
                        r_st <= BK_DIV;
                    end
                end
                BK_DIV: begin
                    if (div_rsp.done) begin
                        r_st <= BK_RUN;
                    end
                end
                default: r_st <= BK_RUN;
            endcase
        end
    end

    // Key, cursor and file constants
    always_ff @(posedge i_clk) begin
        if (div_req.start) begin
            r_key  <= c.key;
            r_half <= c.half;
            r_skip <= c.skip;
            r_plen <= c.plen;
            r_nmh  <= c.plen - c.half;
            r_ws   <= '0;
            r_done <= c.plen < WORD_LEN32;
            r_q    <= '0;
        end else if (r_st == BK_DIV && div_rsp.done) begin
            r_key <= r_key - div_rsp.rem;
        end else if (pop && c.kind == CMD_DATA) begin
            r_q <= r_q + 32'd1;
            if (adv) begin
                r_key  <= r_key - 32'd1;
                r_ws   <= r_s3_ws;
                r_done <= r_s3_done;
            end
        end
    end

    // Hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= pop && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_last <= c.last;
            if (c.kind == CMD_DATA) begin
                r_ob     <= hit ? ob : c.data_byte;
                r_has    <= 1'b1;
                r_sts    <= STS_OK;
                r_endp   <= c.last ? endp : '0;
                r_plen_o <= c.last ? c.plen : '0;
            end else begin
                r_ob     <= '0;
                r_has    <= 1'b0;
                r_sts    <= c.status;
                r_endp   <= '0;
                r_plen_o <= c.plen;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_ob;
    assign o_out.has_byte    = r_has;
    assign o_out.status      = r_sts;
    assign o_out.end_pos     = r_endp;
    assign o_out.payload_len = r_plen_o;
    assign o_out.last        = r_last;

`ifndef SYNTHESIS
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_st == BK_DIV))
        else $error("remainder finished outside key setup");

    a_no_double_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> !adv)
        else $error("cursor advanced on two adjacent bytes");

    a_mid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |->
        (o_out.end_pos == '0 && o_out.payload_len == '0 && o_out.status == STS_OK &&
         o_out.has_byte))
        else $error("summary fields set on a non-final result");

    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.has_byte) |-> (o_out.last && o_out.out_byte == '0))
        else $error("empty result that is not final");
`endif

endmodule

### src/header_keyed_xor_skip_decoder.sv
// Top level of the header keyed XOR skip decoder: front end, queue and back end.
//
//  channel  | dir | payload                                                    | accept
//  i_in     | in  | in_byte, start_flag, file_len                              | valid && ready
//  o_out    | out | out_byte, has_byte, status, end_pos, payload_len, last     | valid && ready
//
// One file byte is taken per cycle while the queue has room; a result passes through a queue
// entry and then the result register before it can be taken.
// After the header's final byte the back end runs the 32-step remainder unit to derive the
// key; the 2-entry queue fills and the input then stalls until the key is set.
// A synchronous low i_rst_n clears control state at once; there is no clearing pass.
// A stalled o_out holds its result and the queue absorbs input until it is full.
module header_keyed_xor_skip_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hkx_in_if.sink    i_in,
    hkx_out_if.source o_out
);
    hkx_cmd_if u_cmd_push ();
    hkx_cmd_if u_cmd_pop ();

    hkx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (u_cmd_push)
    );

    hkx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (u_cmd_push),
        .o_pop   (u_cmd_pop)
    );

    hkx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (u_cmd_pop),
        .o_out   (o_out)
    );

endmodule
